/* sv/p2p_pkg.sv */
// Shared types, register indexes, plane codes and defaults for the packed-nibble
// to planar writer. Used by every module of the block; depends on nothing.
package p2p_pkg;

  localparam int LINE_BYTES_DEF = 80;
  localparam int MAX_WIDTH_DEF  = 640;
  localparam int MAX_HEIGHT_DEF = 400;

  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 400;

  localparam int CFG_DATA_W = 10;
  localparam int WIDTH_W    = 10;
  localparam int HEIGHT_W   = 9;
  localparam int OFFSET_W   = 15;

  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  localparam logic [1:0] PLANE_B = 2'd0;
  localparam logic [1:0] PLANE_G = 2'd1;
  localparam logic [1:0] PLANE_R = 2'd2;
  localparam logic [1:0] PLANE_I = 2'd3;

  typedef struct packed {
    logic                show;
    logic [OFFSET_W-1:0] offset;
    logic                last_word;
  } p2p_pos_t;

  // Gathers one bit of each of the eight nibbles; the leftmost pixel lands in bit 7.
  function automatic logic [7:0] plane_bits(input logic [31:0] word, input logic [1:0] plane);
    logic [7:0] b;
    b = '0;
    for (int k = 0; k < 8; k++) begin
      b[7-k] = word[4*(7-k) + int'(plane)];
    end
    return b;
  endfunction

endpackage

/* sv/p2p_track.sv */
// Configuration registers, word column and screen line tracking, and the plane
// offset of each incoming word. Depends on p2p_pkg.
module p2p_track #(
  parameter int LINE_BYTES = p2p_pkg::LINE_BYTES_DEF,
  parameter int MAX_WIDTH  = p2p_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = p2p_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [0:0]                     cfg_index,
  input  logic [p2p_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_fire,
  output p2p_pkg::p2p_pos_t              pos
);
  import p2p_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH / 8 + 2);
  localparam int LINE_W = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int EW     = 12;
  localparam int HW     = 11;
  localparam int CW     = 9;
  localparam int RST_H  = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;

  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [LINE_W-1:0]   line_r, line_nxt;

  logic [HEIGHT_W-1:0] h_src;
  logic [EW-1:0]       w_ext, eff_w;
  logic [HW-1:0]       h_ext, eff_h;
  logic [LINE_W-1:0]   top_line;
  logic [CW-1:0]       visible, per_row, col_ext, col_inc;
  logic [31:0]         off_full;

  always_comb begin
    h_src = (cfg_we && cfg_index == REG_HEIGHT) ? cfg_data[HEIGHT_W-1:0] : height_r;
    w_ext = EW'(width_r);
    h_ext = HW'(h_src);
    if (w_ext < EW'(8)) begin
      eff_w = EW'(8);
    end else if (w_ext > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = w_ext;
    end
    if (h_ext < HW'(1)) begin
      eff_h = HW'(1);
    end else if (h_ext > HW'(MAX_HEIGHT)) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = h_ext;
    end
    top_line = LINE_W'(eff_h - HW'(1));
    visible  = eff_w[EW-1:3];
    per_row  = CW'((eff_w + EW'(7)) >> 3);
    col_ext  = CW'(col_r);
    col_inc  = col_ext + CW'(1);
    off_full = 32'(line_r) * 32'(LINE_BYTES) + 32'(col_r);

    pos.show      = col_ext < visible;
    pos.offset    = off_full[OFFSET_W-1:0];
    pos.last_word = (line_r == '0) && (col_inc == visible);

    col_nxt  = col_r;
    line_nxt = line_r;
    if (cfg_we) begin
      col_nxt  = '0;
      line_nxt = top_line;
    end else if (in_fire) begin
      if (col_inc >= per_row) begin
        col_nxt  = '0;
        line_nxt = (line_r == '0) ? top_line : line_r - LINE_W'(1);
      end else begin
        col_nxt = COL_W'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_W'(WIDTH_RESET);
      height_r <= HEIGHT_W'(HEIGHT_RESET);
      col_r    <= '0;
      line_r   <= LINE_W'(RST_H - 1);
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WIDTH:  width_r  <= cfg_data[WIDTH_W-1:0];
          REG_HEIGHT: height_r <= cfg_data[HEIGHT_W-1:0];
          default:    width_r  <= width_r;
        endcase
      end
      col_r  <= col_nxt;
      line_r <= line_nxt;
    end
  end

endmodule

/* sv/p2p_split.sv */
// Input word register, plane sequencer and result register. Each held word is
// split into four plane writes, one per unstalled cycle. Depends on p2p_pkg.
module p2p_split (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_fire,
  input  logic [31:0]                  in_word,
  input  p2p_pkg::p2p_pos_t            pos,
  output logic                         take_ok,
  input  logic                         out_tready,
  output logic                         out_valid,
  output logic [1:0]                   out_plane,
  output logic [p2p_pkg::OFFSET_W-1:0] out_offset,
  output logic [7:0]                   out_byte,
  output logic                         out_last,
  output logic                         out_done
);
  import p2p_pkg::*;

  logic                a_valid_r;
  logic [31:0]         a_word_r;
  logic [OFFSET_W-1:0] a_off_r;
  logic                a_last_r;
  logic [1:0]          plane_r;
  logic                o_valid_r;
  logic [1:0]          o_plane_r;
  logic [OFFSET_W-1:0] o_off_r;
  logic [7:0]          o_byte_r;
  logic                o_last_r;
  logic                o_done_r;

  logic out_load, a_pop, a_load;

  assign out_load = a_valid_r && (!o_valid_r || out_tready);
  assign a_pop    = out_load && (plane_r == PLANE_I);
  assign a_load   = in_fire && pos.show;
  assign take_ok  = !a_valid_r || a_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      plane_r   <= PLANE_B;
      o_valid_r <= 1'b0;
    end else begin
      if (a_load) begin
        a_valid_r <= 1'b1;
      end else if (a_pop) begin
        a_valid_r <= 1'b0;
      end
      if (out_load) begin
        plane_r   <= plane_r + 2'd1;
        o_valid_r <= 1'b1;
      end else if (out_tready) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_word_r <= in_word;
      a_off_r  <= pos.offset;
      a_last_r <= pos.last_word;
    end
    if (out_load) begin
      o_plane_r <= plane_r;
      o_off_r   <= a_off_r;
      o_byte_r  <= plane_bits(a_word_r, plane_r);
      o_last_r  <= plane_r == PLANE_I;
      o_done_r  <= (plane_r == PLANE_I) && a_last_r;
    end
  end

  assign out_valid  = o_valid_r;
  assign out_plane  = o_plane_r;
  assign out_offset = o_off_r;
  assign out_byte   = o_byte_r;
  assign out_last   = o_last_r;
  assign out_done   = o_done_r;

endmodule

/* sv/packed_nibble_to_planar_writer_core.sv */
// Top level of the packed-nibble to planar writer: stream ports, configuration
// port and assertions. Depends on p2p_pkg, p2p_track and p2p_split.
//
// Usage:
//   The in_ channel carries 32-bit words of a bottom-up 4-bit-per-pixel bitmap
//   in file order, padding words included. For each visible word the out_
//   channel carries four plane writes (blue, green, red, intensity); padding
//   words are consumed and produce nothing. out_tlast marks the fourth write of
//   a word and out_tuser the fourth write of the last visible word of line 0.
//   The cfg_ port writes width (index 0) or height (index 1);
//   every write restarts the frame at column 0 and line height-1.
//   A word accepted into the input register is split by the sequencer into its
//   plane writes, blue first, which pass through the single result register; it
//   emits one write per cycle while the receiver does not stall it. A new word is
//   accepted in the cycle the held word issues its fourth write.
//   Reset restores width 640 and height 400, empties the word and result
//   registers and restarts the frame. When the receiver stalls, the result
//   register holds, one more word waits in the input register, and in_tready
//   drops until the sequencer can move on.
module packed_nibble_to_planar_writer_core #(
  parameter int LINE_BYTES = p2p_pkg::LINE_BYTES_DEF,
  parameter int MAX_WIDTH  = p2p_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = p2p_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [31:0]                    in_tdata,   // pixel_word
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [31:0]                    out_tdata,  // plane, plane_offset, plane_byte, zeros
  output logic                           out_tlast,  // last_write
  output logic                           out_tuser,  // frame_done
  input  logic                           cfg_we,
  input  logic [0:0]                     cfg_index,
  input  logic [p2p_pkg::CFG_DATA_W-1:0] cfg_data
);
  import p2p_pkg::*;

  logic                in_fire;
  logic                take_ok;
  p2p_pos_t            pos;
  logic [1:0]          res_plane;
  logic [OFFSET_W-1:0] res_offset;
  logic [7:0]          res_byte;

  assign in_tready = take_ok;
  assign in_fire   = in_tvalid && take_ok;

  p2p_track #(
    .LINE_BYTES(LINE_BYTES),
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_track (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_fire  (in_fire),
    .pos      (pos)
  );

  p2p_split u_split (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_word   (in_tdata),
    .pos       (pos),
    .take_ok   (take_ok),
    .out_tready(out_tready),
    .out_valid (out_tvalid),
    .out_plane (res_plane),
    .out_offset(res_offset),
    .out_byte  (res_byte),
    .out_last  (out_tlast),
    .out_done  (out_tuser)
  );

  assign out_tdata = {7'b0, res_byte, res_offset, res_plane};

  a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("frame done flagged on a write that is not the last of its word");

  a_plane_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && (out_tdata[1:0] == $past(out_tdata[1:0]) + 2'd1))
    else $error("plane writes of one word are not consecutive");

  a_offset_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tdata[16:2] == $past(out_tdata[16:2]))
    else $error("plane offset changed within one word");

endmodule
